### design/srlfr_pkg.sv
// Shared types and constants for the start-run frame receiver.
package srlfr_pkg;

  localparam int unsigned BUFFER_DEPTH = 64;
  localparam int unsigned IDX_W = 9;

  localparam logic [1:0] START_RUN = 2'd3;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_SENT    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [1:0] REG_START_CODE   = 2'd0;
  localparam logic [1:0] REG_ACK_VALID    = 2'd1;
  localparam logic [1:0] REG_ACK_INVALID  = 2'd2;

  localparam logic [7:0] START_CODE_RST  = 8'd94;
  localparam logic [7:0] ACK_VALID_RST   = 8'd6;
  localparam logic [7:0] ACK_INVALID_RST = 8'd21;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic       overflow;
    logic       message_done;
    logic       ack_seen;
    logic       nak_seen;
    logic       message_pending;
    logic       awaiting_ack;
  } result_t;

endpackage

### design/srlfr_core.sv
// Frame state, configuration registers and per-item result logic.
module srlfr_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 accept,
  input  logic [1:0]           command,
  input  logic [7:0]           rx_byte,
  output srlfr_pkg::result_t   result
);
  import srlfr_pkg::*;

  logic [7:0] start_code;
  logic [7:0] ack_valid_code;
  logic [7:0] ack_invalid_code;

  logic [1:0] phase, phase_next;
  logic [1:0] start_count, start_count_next;
  logic [7:0] remaining_length, remaining_length_next;
  logic [7:0] write_index, write_index_next;
  logic       pending_flag, pending_flag_next;
  logic       ack_wait_flag, ack_wait_flag_next;
  logic [1:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code       <= START_CODE_RST;
      ack_valid_code   <= ACK_VALID_RST;
      ack_invalid_code <= ACK_INVALID_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_CODE:  start_code       <= cfg_data;
        REG_ACK_VALID:   ack_valid_code   <= cfg_data;
        REG_ACK_INVALID: ack_invalid_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next            = phase;
    start_count_next      = start_count;
    remaining_length_next = remaining_length;
    write_index_next      = write_index;
    pending_flag_next     = pending_flag;
    ack_wait_flag_next    = ack_wait_flag;
    count_inc             = start_count + 2'd1;
    result                = '0;

    case (command)
      CMD_SENT:    ack_wait_flag_next = 1'b1;
      CMD_RELEASE: pending_flag_next  = 1'b0;
      CMD_BYTE: begin
        case (phase)
          PH_IDLE: begin
            if (!pending_flag) begin
              if (rx_byte == start_code) begin
                if (count_inc == START_RUN) begin
                  phase_next       = PH_LEN;
                  start_count_next = 2'd0;
                end else begin
                  start_count_next = count_inc;
                end
              end
            end
          end
          PH_LEN: begin
            remaining_length_next = rx_byte;
            write_index_next      = 8'd0;
            phase_next            = PH_BODY;
          end
          PH_BODY: begin
            if (ack_wait_flag) begin
              if (rx_byte == ack_valid_code) begin
                ack_wait_flag_next = 1'b0;
                phase_next         = PH_IDLE;
                result.ack_seen    = 1'b1;
              end else if (rx_byte == ack_invalid_code) begin
                result.nak_seen = 1'b1;
              end
            end else if (remaining_length != 8'd0) begin
              remaining_length_next = remaining_length - 8'd1;
              if ({1'b0, write_index} < IDX_W'(BUFFER_DEPTH)) begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = write_index[5:0];
              end else begin
                result.overflow = 1'b1;
              end
              if (write_index != 8'hFF) begin
                write_index_next = write_index + 8'd1;
              end
            end else begin
              pending_flag_next   = 1'b1;
              phase_next          = PH_IDLE;
              result.message_done = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    result.message_pending = pending_flag_next;
    result.awaiting_ack    = ack_wait_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      start_count      <= 2'd0;
      remaining_length <= 8'd0;
      write_index      <= 8'd0;
      pending_flag     <= 1'b0;
      ack_wait_flag    <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      start_count      <= start_count_next;
      remaining_length <= remaining_length_next;
      write_index      <= write_index_next;
      pending_flag     <= pending_flag_next;
      ack_wait_flag    <= ack_wait_flag_next;
    end
  end

  a_sent_sets_wait: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_SENT |=> ack_wait_flag)
    else $error("awaiting-ack flag not set after a sent command");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_RELEASE |=> !pending_flag)
    else $error("pending flag not cleared after release");

  a_store_or_drop: assert property (@(posedge clk) disable iff (rst)
    result.payload_valid |-> !result.overflow && phase == PH_BODY && !ack_wait_flag)
    else $error("payload stored outside the body or also flagged as dropped");

  a_len_to_body: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_BYTE && phase == PH_LEN |=> phase == PH_BODY)
    else $error("length byte did not enter the body phase");

endmodule

### design/srlfr_out_stage.sv
// Result register that holds one item until the consumer takes it.
module srlfr_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  srlfr_pkg::result_t result_in,
  output logic               out_valid,
  input  logic               out_ready,
  output srlfr_pkg::result_t result_out
);
  import srlfr_pkg::*;

  logic load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

### design/start_run_length_frame_receiver.sv
// Top level of the start-run frame receiver.
// The result of an item is registered and appears on the output in the cycle after the item is accepted.
// Throughput: one item per cycle unless the consumer holds off with out_ready low; the single
// result register is refilled in the same cycle that the consumer takes its contents.
// Reset (synchronous, active high) returns the frame state to idle, clears all
// flags and counters, and loads the default start, ack and reject codes.
module start_run_length_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic [5:0] payload_index,
  output logic       overflow,
  output logic       message_done,
  output logic       ack_seen,
  output logic       nak_seen,
  output logic       message_pending,
  output logic       awaiting_ack
);
  import srlfr_pkg::*;

  result_t result_next;
  result_t result_q;
  logic    accept;

  assign accept = in_valid && in_ready;

  srlfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .command   (command),
    .rx_byte   (rx_byte),
    .result    (result_next)
  );

  srlfr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .result_in  (result_next),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_q)
  );

  assign payload_valid   = result_q.payload_valid;
  assign payload_byte    = result_q.payload_byte;
  assign payload_index   = result_q.payload_index;
  assign overflow        = result_q.overflow;
  assign message_done    = result_q.message_done;
  assign ack_seen        = result_q.ack_seen;
  assign nak_seen        = result_q.nak_seen;
  assign message_pending = result_q.message_pending;
  assign awaiting_ack    = result_q.awaiting_ack;

endmodule

### tb/tb_start_run_length_frame_receiver.sv
// Self-checking testbench for the start-run frame receiver with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_start_run_length_frame_receiver;
  import srlfr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CHUNK_ITEMS = 226;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;

  class frame_rx_scoreboard;
    logic [7:0] start_code;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
    logic [1:0] frame_phase;
    logic [1:0] start_count;
    logic [7:0] bytes_left;
    logic [7:0] write_idx;
    logic       pending;
    logic       ack_wait;
    result_t    results_due[$];
    int         errors;
    int         checked;

    function new();
      start_code = START_CODE_RST;
      ack_code = ACK_VALID_RST;
      nak_code = ACK_INVALID_RST;
      frame_phase = PH_IDLE;
      start_count = '0;
      bytes_left = '0;
      write_idx = '0;
      pending = 1'b0;
      ack_wait = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_START_CODE: start_code = val;
        REG_ACK_VALID: ack_code = val;
        REG_ACK_INVALID: nak_code = val;
        default: ;
      endcase
    endfunction

    function void take_item(logic [1:0] cmd, logic [7:0] data);
      result_t r;
      r = '0;
      case (cmd)
        CMD_SENT: ack_wait = 1'b1;
        CMD_RELEASE: pending = 1'b0;
        CMD_BYTE: begin
          case (frame_phase)
            PH_IDLE: begin
              if (!pending) begin
                if (data == start_code) start_count = start_count + 2'd1;
                if (start_count == START_RUN) begin
                  frame_phase = PH_LEN;
                  start_count = '0;
                end
              end
            end
            PH_LEN: begin
              bytes_left = data;
              write_idx = '0;
              frame_phase = PH_BODY;
            end
            PH_BODY: begin
              if (ack_wait) begin
                if (data == ack_code) begin
                  ack_wait = 1'b0;
                  frame_phase = PH_IDLE;
                  r.ack_seen = 1'b1;
                end else if (data == nak_code) begin
                  r.nak_seen = 1'b1;
                end
              end else if (bytes_left != 8'd0) begin
                bytes_left = bytes_left - 8'd1;
                if (write_idx < BUFFER_DEPTH) begin
                  r.payload_valid = 1'b1;
                  r.payload_byte = data;
                  r.payload_index = write_idx[5:0];
                end else begin
                  r.overflow = 1'b1;
                end
                if (write_idx != 8'd255) write_idx = write_idx + 8'd1;
              end else begin
                pending = 1'b1;
                frame_phase = PH_IDLE;
                r.message_done = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      r.message_pending = pending;
      r.awaiting_ack = ack_wait;
      results_due.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (results_due.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare_field("payload_valid", want.payload_valid, got.payload_valid);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("message_done", want.message_done, got.message_done);
      compare_field("ack_seen", want.ack_seen, got.ack_seen);
      compare_field("nak_seen", want.nak_seen, got.nak_seen);
      compare_field("message_pending", want.message_pending, got.message_pending);
      compare_field("awaiting_ack", want.awaiting_ack, got.awaiting_ack);
    endfunction

    function int outstanding();
      return results_due.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] command = CMD_BYTE;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [5:0] payload_index;
  logic       overflow;
  logic       message_done;
  logic       ack_seen;
  logic       nak_seen;
  logic       message_pending;
  logic       awaiting_ack;

  frame_rx_scoreboard sb;
  logic no_idle = 1'b0;
  logic held_off = 1'b0;
  int   len_picks = 0;
  int   idle_cycles = 0;

  start_run_length_frame_receiver DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .payload_valid(payload_valid),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .overflow(overflow),
    .message_done(message_done),
    .ack_seen(ack_seen),
    .nak_seen(nak_seen),
    .message_pending(message_pending),
    .awaiting_ack(awaiting_ack)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    rx_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_item(cmd, data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_codes(input logic [7:0] start_val, input logic [7:0] ack_val,
                             input logic [7:0] nak_val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_START_CODE;
    cfg_data <= start_val;
    @(negedge clk);
    cfg_index <= REG_ACK_VALID;
    cfg_data <= ack_val;
    @(negedge clk);
    cfg_index <= REG_ACK_INVALID;
    cfg_data <= nak_val;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(REG_START_CODE, start_val);
    sb.write_reg(REG_ACK_VALID, ack_val);
    sb.write_reg(REG_ACK_INVALID, nak_val);
  endtask

  // Chooses the next item from the predicted frame state so that most traffic forms
  // complete frames, with a little noise and broken sequences mixed in.
  task automatic pick_item(output logic [1:0] cmd, output logic [7:0] data);
    int roll;
    roll = $urandom_range(0, 99);
    cmd = CMD_BYTE;
    data = 8'($urandom_range(0, 255));
    if (roll < 4) begin
      cmd = 2'($urandom_range(0, 3));
    end else begin
      case (sb.frame_phase)
        PH_IDLE: begin
          if (sb.pending) begin
            if (roll < 50) cmd = CMD_RELEASE;
            else if (roll < 55) cmd = CMD_SENT;
          end else if (roll < 65) begin
            data = sb.start_code;
          end else if (roll < 68) begin
            cmd = CMD_SENT;
          end
        end
        PH_LEN: begin
          len_picks++;
          if (len_picks == 20) data = 8'd255;
          else if (len_picks % 12 == 5) data = 8'($urandom_range(65, 90));
          else if (roll < 82) data = 8'($urandom_range(0, 8));
          else if (roll < 94) data = 8'($urandom_range(9, 40));
          else if (roll < 99) data = 8'($urandom_range(60, 80));
          else data = 8'd255;
        end
        PH_BODY: begin
          if (sb.ack_wait) begin
            if (roll < 45) data = sb.ack_code;
            else if (roll < 65) data = sb.nak_code;
          end else if (roll < 6) begin
            cmd = CMD_SENT;
          end else if (roll < 8) begin
            cmd = CMD_UNUSED;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic run_random(input int count);
    logic [1:0] cmd;
    logic [7:0] data;
    for (int i = 0; i < count; i++) begin
      pick_item(cmd, data);
      send_item(cmd, data);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result({payload_valid, payload_byte, payload_index, overflow, message_done,
                       ack_seen, nak_seen, message_pending, awaiting_ack});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int roll;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held_off && sb.checked >= 400) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 72) begin
          out_ready <= 1'b1;
        end else if (roll < 94) begin
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(4, 30)) @(negedge clk);
        end
      end
    end
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(CMD_UNUSED, 8'hFF);
    send_item(CMD_BYTE, START_CODE_RST);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_SENT, 8'hAA);
    send_item(CMD_BYTE, START_CODE_RST);
    send_item(CMD_BYTE, START_CODE_RST);
    send_item(CMD_BYTE, 8'd0);
    send_item(CMD_BYTE, 8'h55);
    send_item(CMD_BYTE, ACK_INVALID_RST);
    send_item(CMD_BYTE, ACK_VALID_RST);
    send_item(CMD_BYTE, START_CODE_RST);
    send_item(CMD_BYTE, START_CODE_RST);
    send_item(CMD_BYTE, START_CODE_RST);
    send_item(CMD_BYTE, 8'd2);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_RELEASE, 8'h00);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h33);
    send_item(CMD_BYTE, START_CODE_RST);
    send_item(CMD_BYTE, START_CODE_RST);
    send_item(CMD_RELEASE, 8'hFF);
    send_item(CMD_BYTE, START_CODE_RST);
    run_random(CHUNK_ITEMS);

    write_codes(8'd0, 8'd255, 8'd128);
    run_random(CHUNK_ITEMS);

    write_codes(8'd255, 8'd0, 8'd255);
    no_idle = 1'b1;
    run_random(CHUNK_ITEMS);
    no_idle = 1'b0;

    // The ack and reject codes are equal here, so the ack has to win.
    write_codes(START_CODE_RST, ACK_VALID_RST, ACK_VALID_RST);
    run_random(CHUNK_ITEMS);

    write_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    run_random(CHUNK_ITEMS);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
